/* hw/rtl/lgps_pkg.sv */
// Shared types and constants for the legged gait phase scheduler.
// No dependencies; every other file of the block imports this package.
package lgps_pkg;

    localparam int MAX_SEGMENTS_DEF  = 16;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int TICK_W            = 31;
    localparam int TPS_W             = 8;
    localparam int NSEG_W            = 5;
    localparam int OFF_W             = 4;
    localparam int DUR_W             = 5;
    localparam int LEGS              = 4;
    localparam int CFG_W             = 20;
    localparam int CFG_ADDR_W        = 2;
    localparam int SEG_W             = 4;
    // Widest period: 16 segments of 255 ticks
    localparam int P_W               = 12;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_NUM_SEGMENTS      = 2'd0,
        CFG_TICKS_PER_SEGMENT = 2'd1,
        CFG_LEG_OFFSETS       = 2'd2,
        CFG_LEG_DURATIONS     = 2'd3
    } t_cfg_addr;

    // Clamped settings and tick-scaled leg timing, derived from the registers
    typedef struct packed {
        logic [NSEG_W-1:0]               nseg;
        logic [TPS_W-1:0]                tps;
        logic [P_W-1:0]                  period;
        logic [LEGS-1:0][NSEG_W-1:0]     off;
        logic [LEGS-1:0][NSEG_W-1:0]     dur;
        logic [LEGS-1:0][P_W-1:0]        off_t;
        logic [LEGS-1:0][P_W-1:0]        dur_t;
        logic [LEGS-1:0][P_W-1:0]        swing_t;
    } t_sched_cfg;

    // Item passed from front to back: segment and tick within segment
    typedef struct packed {
        logic [SEG_W-1:0] seg;
        logic [TPS_W-1:0] sub;
    } t_qitem;

endpackage

/* hw/rtl/lgps_front.sv */
// Front end: pipelined restoring division of the tick by ticks per segment,
// folding quotient bits into a running remainder modulo the segment count.
// Depends on lgps_pkg.
module lgps_front
    import lgps_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_sched_cfg        i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [TICK_W-1:0] i_tick,
    output logic              o_valid,
    input  logic              i_ready,
    output t_qitem            o_item
);

    localparam int NS = TICK_W;

    logic                   r_v    [NS];
    logic [TICK_W-1:0]      r_tick [NS];
    logic [TPS_W-1:0]       r_rem  [NS];
    logic [NSEG_W-1:0]      r_mod  [NS];
    logic [TPS_W-1:0]       n_rem  [NS];
    logic [NSEG_W-1:0]      n_mod  [NS];
    logic                   en;

    assign en      = !r_v[NS-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_v[NS-1];
    assign o_item  = '{seg: r_mod[NS-1][SEG_W-1:0], sub: r_rem[NS-1]};

    always_comb begin
        logic [TICK_W-1:0] s_tick;
        logic [TPS_W-1:0]  s_rem;
        logic [NSEG_W-1:0] s_mod;
        logic [TPS_W:0]    x;
        logic [NSEG_W:0]   m;
        logic              ge;
        for (int k = 0; k < NS; k++) begin
            s_tick = (k == 0) ? i_tick : r_tick[k-1];
            s_rem  = (k == 0) ? '0 : r_rem[k-1];
            s_mod  = (k == 0) ? '0 : r_mod[k-1];
            x  = {s_rem, s_tick[TICK_W-1-k]};
            ge = x >= {1'b0, i_cfg.tps};
            x  = ge ? x - {1'b0, i_cfg.tps} : x;
            n_rem[k] = x[TPS_W-1:0];
            m  = {s_mod, ge};
            m  = (m >= {1'b0, i_cfg.nseg}) ? m - {1'b0, i_cfg.nseg} : m;
            n_mod[k] = m[NSEG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) r_v[k] <= 1'b0;
        end else if (en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < NS; k++) r_v[k] <= r_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tick[0] <= i_tick;
            for (int k = 1; k < NS; k++) r_tick[k] <= r_tick[k-1];
            for (int k = 0; k < NS; k++) begin
                r_rem[k] <= n_rem[k];
                r_mod[k] <= n_mod[k];
            end
        end
    end

endmodule

/* hw/rtl/lgps_queue.sv */
// Two-entry queue between front and back ends.
// Depends on lgps_pkg.
module lgps_queue
    import lgps_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_qitem i_item,
    output logic   o_valid,
    input  logic   i_ready,
    output t_qitem o_item
);

    t_qitem     r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_item  = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_item;
    end

endmodule

/* hw/rtl/lgps_back.sv */
// Back end: cycle position, per-leg stance/swing set-up, contact table,
// then five pipelined fraction dividers one quotient bit per stage.
// Depends on lgps_pkg.
module lgps_back
    import lgps_pkg::*;
#(
    parameter int MAX_SEGMENTS  = MAX_SEGMENTS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  t_sched_cfg                       i_cfg,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  t_qitem                           i_item,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [SEG_W-1:0]                 o_seg,
    output logic [FRACTION_BITS-1:0]         o_phase,
    output logic [LEGS-1:0][FRACTION_BITS:0] o_stance,
    output logic [LEGS-1:0][FRACTION_BITS:0] o_swing,
    output logic [4*MAX_SEGMENTS-1:0]        o_table
);

    localparam int ND = LEGS + 1;          // phase divider plus one per leg
    localparam int DS = FRACTION_BITS + 1; // quotient bits
    localparam int TB = 4 * MAX_SEGMENTS;
    localparam int IW = NSEG_W + 2;

    logic en;

    // stage A: position in cycle
    logic             r_av;
    logic [SEG_W-1:0] r_aseg;
    logic [P_W-1:0]   r_apos;

    // stage B: divider operands and table
    logic             r_bv;
    logic [SEG_W-1:0] r_bseg;
    logic [TB-1:0]    r_btab;
    logic [P_W-1:0]   r_bnum [ND];
    logic [P_W-1:0]   r_bden [ND];
    logic [LEGS-1:0]  r_bstn;
    logic [P_W-1:0]   n_bnum [ND];
    logic [P_W-1:0]   n_bden [ND];
    logic [LEGS-1:0]  n_bstn;
    logic [TB-1:0]    n_btab;

    // divider stages
    logic             r_v    [DS];
    logic [SEG_W-1:0] r_seg  [DS];
    logic [TB-1:0]    r_tab  [DS];
    logic [LEGS-1:0]  r_stn  [DS];
    logic [P_W-1:0]   r_rem  [DS][ND];
    logic [P_W-1:0]   r_den  [DS][ND];
    logic [DS-1:0]    r_q    [DS][ND];
    logic [P_W-1:0]   n_rem  [DS][ND];
    logic [DS-1:0]    n_q    [DS][ND];

    assign en      = !r_v[DS-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_v[DS-1];
    assign o_seg   = r_seg[DS-1];
    assign o_table = r_btab_out();
    assign o_phase = r_q[DS-1][0][FRACTION_BITS-1:0];

    function automatic logic [TB-1:0] r_btab_out();
        return r_tab[DS-1];
    endfunction

    always_comb begin
        for (int j = 0; j < LEGS; j++) begin
            o_stance[j] = r_stn[DS-1][j] ? r_q[DS-1][j+1] : '0;
            o_swing[j]  = r_stn[DS-1][j] ? '0 : r_q[DS-1][j+1];
        end
    end

    // stage B operands
    always_comb begin
        logic [P_W:0]   lp;
        logic [P_W-1:0] lpt;
        logic [IW-1:0]  it;
        logic [IW-1:0]  prog;
        n_bnum[0] = r_apos;
        n_bden[0] = i_cfg.period;
        for (int j = 0; j < LEGS; j++) begin
            lp = (r_apos >= i_cfg.off_t[j])
               ? {1'b0, r_apos} - {1'b0, i_cfg.off_t[j]}
               : {1'b0, r_apos} + {1'b0, i_cfg.period} - {1'b0, i_cfg.off_t[j]};
            lpt = lp[P_W-1:0];
            n_bstn[j] = lpt <= i_cfg.dur_t[j];
            if (n_bstn[j]) begin
                n_bnum[j+1] = lpt;
                n_bden[j+1] = (i_cfg.dur_t[j] == '0) ? P_W'(1) : i_cfg.dur_t[j];
            end else begin
                n_bnum[j+1] = lpt - i_cfg.dur_t[j];
                n_bden[j+1] = i_cfg.swing_t[j];
            end
        end
        n_btab = '0;
        for (int i = 0; i < MAX_SEGMENTS; i++) begin
            it = IW'(r_aseg) + IW'(1) + IW'(i);
            if (it >= IW'(i_cfg.nseg)) it = it - IW'(i_cfg.nseg);
            for (int j = 0; j < LEGS; j++) begin
                prog = (it >= IW'(i_cfg.off[j]))
                     ? it - IW'(i_cfg.off[j])
                     : it + IW'(i_cfg.nseg) - IW'(i_cfg.off[j]);
                n_btab[4*i+j] = (IW'(i) < IW'(i_cfg.nseg)) && (prog < IW'(i_cfg.dur[j]));
            end
        end
    end

    // one restoring step per stage; the first step takes the numerator unshifted
    always_comb begin
        logic [P_W:0]   x;
        logic [P_W-1:0] den;
        logic [DS-1:0]  q;
        logic           ge;
        for (int k = 0; k < DS; k++) begin
            for (int d = 0; d < ND; d++) begin
                if (k == 0) begin
                    x   = {1'b0, r_bnum[d]};
                    den = r_bden[d];
                    q   = '0;
                end else begin
                    x   = {r_rem[k-1][d], 1'b0};
                    den = r_den[k-1][d];
                    q   = r_q[k-1][d];
                end
                ge = x >= {1'b0, den};
                x  = ge ? x - {1'b0, den} : x;
                n_rem[k][d] = x[P_W-1:0];
                n_q[k][d]   = {q[DS-2:0], ge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av <= 1'b0;
            r_bv <= 1'b0;
            for (int k = 0; k < DS; k++) r_v[k] <= 1'b0;
        end else if (en) begin
            r_av <= i_valid;
            r_bv <= r_av;
            r_v[0] <= r_bv;
            for (int k = 1; k < DS; k++) r_v[k] <= r_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_aseg <= i_item.seg;
            r_apos <= P_W'(i_item.seg) * P_W'(i_cfg.tps) + P_W'(i_item.sub);
            r_bseg <= r_aseg;
            r_btab <= n_btab;
            r_bstn <= n_bstn;
            for (int d = 0; d < ND; d++) begin
                r_bnum[d] <= n_bnum[d];
                r_bden[d] <= n_bden[d];
            end
            for (int k = 0; k < DS; k++) begin
                r_seg[k] <= (k == 0) ? r_bseg : r_seg[k-1];
                r_tab[k] <= (k == 0) ? r_btab : r_tab[k-1];
                r_stn[k] <= (k == 0) ? r_bstn : r_stn[k-1];
                for (int d = 0; d < ND; d++) begin
                    r_den[k][d] <= (k == 0) ? r_bden[d] : r_den[k-1][d];
                    r_rem[k][d] <= n_rem[k][d];
                    r_q[k][d]   <= n_q[k][d];
                end
            end
        end
    end

endmodule

/* hw/rtl/legged_gait_phase_scheduler.sv */
// Four-leg gait phase scheduler, top level. Items pass the front end, the queue,
// the set-up stages and the dividers. Throughput: one item per cycle unless the
// output stalls; set by the fully pipelined tick divider in the front end and
// the one-bit-per-stage fraction dividers in the back end.
// Reset (synchronous, active low) empties all pipelines and the queue and
// loads the registers with 10 segments, 1 tick, zero offsets, durations of 5.
// Depends on lgps_pkg, lgps_front, lgps_queue and lgps_back.
module legged_gait_phase_scheduler
    import lgps_pkg::*;
#(
    parameter int MAX_SEGMENTS  = MAX_SEGMENTS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    localparam int SW   = $clog2(MAX_SEGMENTS),
    localparam int OUTB = SW + FRACTION_BITS + 8 * (FRACTION_BITS + 1) + 4 * MAX_SEGMENTS,
    localparam int OUTW = ((OUTB + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_data,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [31:0]           s_axis_tdata,  // tick_count[30:0], zero pad
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // segment_index, cycle_phase, stance_leg0..3, swing_leg0..3,
    // contact_table, zero pad
    output logic [OUTW-1:0]       m_axis_tdata
);

    // configuration registers
    logic [NSEG_W-1:0]         r_nseg;
    logic [TPS_W-1:0]          r_tps;
    logic [LEGS*OFF_W-1:0]     r_offs;
    logic [LEGS*DUR_W-1:0]     r_durs;

    // clamped and tick-scaled settings, refreshed every cycle
    t_sched_cfg                r_cfg;
    t_sched_cfg                n_cfg;
    logic [NSEG_W-1:0]         r_ncl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nseg <= NSEG_W'(10);
            r_tps  <= TPS_W'(1);
            r_offs <= '0;
            r_durs <= (LEGS*DUR_W)'(169125);
        end else if (i_cfg_we) begin
            case (t_cfg_addr'(i_cfg_addr))
                CFG_NUM_SEGMENTS:      r_nseg <= i_cfg_data[NSEG_W-1:0];
                CFG_TICKS_PER_SEGMENT: r_tps  <= i_cfg_data[TPS_W-1:0];
                CFG_LEG_OFFSETS:       r_offs <= i_cfg_data[LEGS*OFF_W-1:0];
                CFG_LEG_DURATIONS:     r_durs <= i_cfg_data[LEGS*DUR_W-1:0];
                default:               r_nseg <= r_nseg;
            endcase
        end
    end

    // clamp segment count, ticks, offsets and durations; scale by ticks
    always_comb begin
        logic [NSEG_W-1:0] o;
        logic [NSEG_W-1:0] d;
        n_cfg.nseg = (r_nseg == '0) ? NSEG_W'(1)
                   : (r_nseg > NSEG_W'(MAX_SEGMENTS)) ? NSEG_W'(MAX_SEGMENTS) : r_nseg;
        n_cfg.tps    = (r_tps == '0) ? TPS_W'(1) : r_tps;
        n_cfg.period = P_W'(n_cfg.nseg) * P_W'(n_cfg.tps);
        for (int j = 0; j < LEGS; j++) begin
            o = NSEG_W'(r_offs[OFF_W*j +: OFF_W]);
            d = r_durs[DUR_W*j +: DUR_W];
            if (o > n_cfg.nseg - NSEG_W'(1)) o = n_cfg.nseg - NSEG_W'(1);
            if (d > n_cfg.nseg) d = n_cfg.nseg;
            n_cfg.off[j]     = o;
            n_cfg.dur[j]     = d;
            n_cfg.off_t[j]   = P_W'(o) * P_W'(n_cfg.tps);
            n_cfg.dur_t[j]   = P_W'(d) * P_W'(n_cfg.tps);
            n_cfg.swing_t[j] = n_cfg.period - P_W'(d) * P_W'(n_cfg.tps);
        end
    end

    always_ff @(posedge i_clk) begin
        r_cfg <= n_cfg;
        r_ncl <= n_cfg.nseg;
    end

    // front end -> queue -> back end
    logic   f_valid, f_ready;
    t_qitem f_item;
    logic   q_valid, q_ready;
    t_qitem q_item;

    logic [SEG_W-1:0]                 b_seg;
    logic [FRACTION_BITS-1:0]         b_phase;
    logic [LEGS-1:0][FRACTION_BITS:0] b_stance;
    logic [LEGS-1:0][FRACTION_BITS:0] b_swing;
    logic [4*MAX_SEGMENTS-1:0]        b_table;

    lgps_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_tick  (s_axis_tdata[TICK_W-1:0]),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_item  (f_item)
    );

    lgps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_item  (f_item),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_item  (q_item)
    );

    lgps_back #(
        .MAX_SEGMENTS  (MAX_SEGMENTS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (q_valid),
        .o_ready  (q_ready),
        .i_item   (q_item),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_seg    (b_seg),
        .o_phase  (b_phase),
        .o_stance (b_stance),
        .o_swing  (b_swing),
        .o_table  (b_table)
    );

    // pack the result item, segment index in the lowest bits
    assign m_axis_tdata = OUTW'({b_table, b_swing[3], b_swing[2], b_swing[1], b_swing[0],
                                 b_stance[3], b_stance[2], b_stance[1], b_stance[0],
                                 b_phase, b_seg[SW-1:0]});

    // leg 0 is never in stance and swing at once
    a_leg_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (b_stance[0] != '0) |-> (b_swing[0] == '0))
        else $error("leg 0 reports stance and swing together");

    // segment index stays below the clamped segment count
    a_seg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (NSEG_W'(b_seg) < r_ncl))
        else $error("segment index out of range");

    // no result straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule
